FILE: hdl/text_mode_character_writer_macros.svh
// assertion helpers shared by the console engine modules
`ifndef TEXT_MODE_CHARACTER_WRITER_MACROS_SVH
`define TEXT_MODE_CHARACTER_WRITER_MACROS_SVH

// expression holds at every clock edge out of reset
`define TMCW_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define TMCW_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

FILE: hdl/tmcw_pkg.sv
package tmcw_pkg;

    localparam int unsigned COLUMNS  = 80;
    localparam int unsigned ROWS     = 25;
    localparam int unsigned CELLS    = COLUMNS * ROWS;
    localparam int unsigned COL_W    = $clog2(COLUMNS);
    localparam int unsigned ROW_W    = $clog2(ROWS);
    localparam int unsigned ADDR_W   = $clog2(CELLS);
    localparam int unsigned CELL_W   = 16;
    localparam int unsigned POS_W    = 11;
    localparam int unsigned COLOR_W  = 4;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned TAB_STEP = 3;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_SET   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_FG = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BG = 1'd1;

    localparam logic [COLOR_W-1:0] FG_RESET = 4'hF;
    localparam logic [COLOR_W-1:0] BG_RESET = 4'h0;

    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_SPACE   = 8'd32;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  char_code;
        logic [6:0]  target_col;
        logic [4:0]  target_row;
        logic [10:0] cell_address;
    } t_in_item;

    typedef struct packed {
        logic [10:0] cursor_position;
        logic [15:0] cell_data;
    } t_out_item;

    // cursor update request from the control engine
    typedef struct packed {
        logic        en;
        logic [1:0]  opcode;
        logic [7:0]  char_code;
        logic [6:0]  target_col;
        logic [4:0]  target_row;
    } t_cur_cmd;

    typedef struct packed {
        logic [ADDR_W-1:0] pos;
        logic [ADDR_W-1:0] pos_next;
        logic              scroll;
    } t_cur_stat;

    function automatic logic [CELL_W-1:0] attr_word(input logic [7:0] ch,
                                                    input logic [COLOR_W-1:0] fg,
                                                    input logic [COLOR_W-1:0] bg);
        attr_word = {bg, fg, ch};
    endfunction

endpackage

FILE: hdl/tmcw_ram.sv
module tmcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/tmcw_cursor.sv
`include "text_mode_character_writer_macros.svh"

module tmcw_cursor (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tmcw_pkg::t_cur_cmd  i_cmd,
    output tmcw_pkg::t_cur_stat o_stat
);

    import tmcw_pkg::*;

    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] n_row;
    logic [COL_W:0]   put_col;
    logic [ROW_W:0]   put_row;
    logic             put_scroll;
    logic             cur_scroll;

    // put character: advance, wrap, and flag a scroll when passing the last row
    always_comb begin
        put_col = {1'b0, r_col};
        put_row = {1'b0, r_row};
        if (i_cmd.char_code == CH_NEWLINE) begin
            put_col = '0;
            put_row = {1'b0, r_row} + (ROW_W+1)'(1);
        end else if (i_cmd.char_code == CH_TAB) begin
            put_col = {1'b0, r_col} + (COL_W+1)'(TAB_STEP);
        end else begin
            put_col = {1'b0, r_col} + (COL_W+1)'(1);
        end
        if (put_col >= (COL_W+1)'(COLUMNS)) begin
            put_col = '0;
            put_row = put_row + (ROW_W+1)'(1);
        end
        put_scroll = 1'b0;
        if (put_row >= (ROW_W+1)'(ROWS)) begin
            put_scroll = 1'b1;
            put_row    = (ROW_W+1)'(ROWS - 1);
        end
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        cur_scroll = 1'b0;
        if (i_cmd.en) begin
            case (i_cmd.opcode)
                OP_PUT: begin
                    n_col = put_col[COL_W-1:0];
                    n_row = put_row[ROW_W-1:0];
                    cur_scroll = put_scroll;
                end
                OP_SET: begin
                    n_col = (32'(i_cmd.target_col) < COLUMNS) ?
                            COL_W'(i_cmd.target_col) : COL_W'(COLUMNS - 1);
                    n_row = (32'(i_cmd.target_row) < ROWS) ?
                            ROW_W'(i_cmd.target_row) : ROW_W'(ROWS - 1);
                end
                OP_CLEAR: begin
                    n_col = '0;
                    n_row = '0;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_stat.scroll   = cur_scroll;
    assign o_stat.pos      = ADDR_W'(r_row) * ADDR_W'(COLUMNS) + ADDR_W'(r_col);
    assign o_stat.pos_next = ADDR_W'(n_row) * ADDR_W'(COLUMNS) + ADDR_W'(n_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    `TMCW_ASSERT_ALWAYS(a_cursor_in_grid, i_clk, i_rst_n, (32'(r_col) < COLUMNS) && (32'(r_row) < ROWS), "cursor left the grid")

endmodule

FILE: hdl/text_mode_character_writer.sv
// channel  | direction | handshake                 | payload
// in       | input     | i_in_valid / o_in_ready   | i_in_item  (t_in_item)
// out      | output    | o_out_valid / i_out_ready | o_out_item (t_out_item)
// cfg      | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// put (no scroll) and set cursor load the out register straight from idle; read cell
// passes through the read state to take the registered ram data. a scroll moves the cell
// ram one word per cycle through its single write port, then passes the drain state;
// clear writes one cell per cycle. after reset a zero-fill pass runs with o_in_ready low.
// an item is taken only when the out register is free or emptied in the same cycle.
`include "text_mode_character_writer_macros.svh"

module text_mode_character_writer (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  tmcw_pkg::t_in_item        i_in_item,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output tmcw_pkg::t_out_item       o_out_item,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [tmcw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tmcw_pkg::COLOR_W-1:0]   i_cfg_data
);

    import tmcw_pkg::*;

    typedef enum logic [5:0] {
        S_INIT   = 6'b000001,
        S_IDLE   = 6'b000010,
        S_READ   = 6'b000100,
        S_SCROLL = 6'b001000,
        S_DRAIN  = 6'b010000,
        S_CLEAR  = 6'b100000
    } t_state;

    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_cnt, n_cnt;
    logic                r_mv_valid;
    logic                r_mv_zero;
    logic [ADDR_W-1:0]   r_mv_addr;
    logic                r_rd_ok, n_rd_ok;
    logic                r_out_valid;
    t_out_item           r_out, n_out;
    logic                load_out;
    logic [COLOR_W-1:0]  r_fg, r_bg;

    logic                in_fire;
    logic                out_fire;
    logic                cnt_last;
    logic                put_cell;
    logic                rd_in_grid;
    t_cur_cmd            cur_cmd;
    t_cur_stat           cur_stat;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [CELL_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [CELL_W-1:0]   ram_rdata;

    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_fire    = r_out_valid && i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign o_cfg_ready = 1'b1;
    assign cnt_last    = (r_cnt == ADDR_W'(CELLS - 1));
    assign put_cell    = (i_in_item.opcode == OP_PUT) && (i_in_item.char_code != CH_NEWLINE)
                         && (i_in_item.char_code != CH_TAB);
    assign rd_in_grid  = 32'(i_in_item.cell_address) < CELLS;

    assign cur_cmd.en         = in_fire;
    assign cur_cmd.opcode     = i_in_item.opcode;
    assign cur_cmd.char_code  = i_in_item.char_code;
    assign cur_cmd.target_col = i_in_item.target_col;
    assign cur_cmd.target_row = i_in_item.target_row;

    tmcw_cursor u_cursor (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cur_cmd),
        .o_stat  (cur_stat)
    );

    tmcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // single write port: scroll move stage, fill sweeps, then character puts
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_cnt;
        ram_wdata = '0;
        if (r_mv_valid) begin
            ram_we    = 1'b1;
            ram_waddr = r_mv_addr;
            ram_wdata = r_mv_zero ? '0 : ram_rdata;
        end else if (r_state == S_INIT) begin
            ram_we    = 1'b1;
        end else if (r_state == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_wdata = attr_word(CH_SPACE, r_fg, r_bg);
        end else if (in_fire && put_cell) begin
            ram_we    = 1'b1;
            ram_waddr = cur_stat.pos;
            ram_wdata = attr_word(i_in_item.char_code, r_fg, r_bg);
        end
    end

    // scroll reads one row ahead of the write stage
    always_comb begin
        if (r_state == S_SCROLL) begin
            ram_re    = r_cnt < ADDR_W'(CELLS - COLUMNS);
            ram_raddr = r_cnt + ADDR_W'(COLUMNS);
        end else begin
            ram_re    = in_fire && (i_in_item.opcode == OP_READ) && rd_in_grid;
            ram_raddr = ADDR_W'(i_in_item.cell_address);
        end
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_rd_ok  = r_rd_ok;
        load_out = 1'b0;
        n_out.cursor_position = POS_W'(cur_stat.pos);
        n_out.cell_data       = '0;
        case (r_state)
            S_INIT: begin
                n_cnt = r_cnt + ADDR_W'(1);
                if (cnt_last) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_fire) begin
                    case (i_in_item.opcode)
                        OP_PUT: begin
                            if (cur_stat.scroll) begin
                                n_cnt   = '0;
                                n_state = S_SCROLL;
                            end else begin
                                load_out = 1'b1;
                                n_out.cursor_position = POS_W'(cur_stat.pos_next);
                            end
                        end
                        OP_SET: begin
                            load_out = 1'b1;
                            n_out.cursor_position = POS_W'(cur_stat.pos_next);
                        end
                        OP_CLEAR: begin
                            n_cnt   = '0;
                            n_state = S_CLEAR;
                        end
                        default: begin
                            n_rd_ok = rd_in_grid;
                            n_state = S_READ;
                        end
                    endcase
                end
            end
            S_READ: begin
                load_out = 1'b1;
                n_out.cell_data = r_rd_ok ? ram_rdata : '0;
                n_state = S_IDLE;
            end
            S_SCROLL: begin
                n_cnt = r_cnt + ADDR_W'(1);
                if (cnt_last) begin
                    n_cnt   = '0;
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                load_out = 1'b1;
                n_state  = S_IDLE;
            end
            S_CLEAR: begin
                n_cnt = r_cnt + ADDR_W'(1);
                if (cnt_last) begin
                    n_cnt    = '0;
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_cnt       <= '0;
            r_mv_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_rd_ok     <= 1'b0;
            r_fg        <= FG_RESET;
            r_bg        <= BG_RESET;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_mv_valid <= (r_state == S_SCROLL);
            r_rd_ok    <= n_rd_ok;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (out_fire) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_FG:  r_fg <= i_cfg_data;
                    REG_BG:  r_bg <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mv_addr <= r_cnt;
        r_mv_zero <= r_cnt >= ADDR_W'(CELLS - COLUMNS);
        if (load_out) begin
            r_out <= n_out;
        end
    end

    `TMCW_ASSERT_IMPLIES(a_ready_only_idle, i_clk, i_rst_n, o_in_ready, (r_state == S_IDLE) && !r_mv_valid, "item taken while engine busy")
    `TMCW_ASSERT_IMPLIES(a_move_in_scroll, i_clk, i_rst_n, r_mv_valid, (r_state == S_SCROLL) || (r_state == S_DRAIN), "row move write outside scroll")
    `TMCW_ASSERT_IMPLIES(a_late_result_slot, i_clk, i_rst_n, load_out && (r_state != S_IDLE), !r_out_valid, "late result overwrites pending item")

endmodule
